FILE: rtl/afd_pkg.sv
// Shared widths, register indexes, reset values and types of the fall detector.
`default_nettype none
package afd_pkg;

   localparam int ACCEL_W   = 16;
   localparam int GAIN_W    = 16;
   localparam int OFFSET_W  = 17;
   localparam int LEVEL_W   = 40;
   localparam int TIME_W    = 32;
   localparam int MAG_W     = 40;
   localparam int MODE_W    = 2;
   localparam int PROD_W    = ACCEL_W + GAIN_W + 1;
   localparam int SCALE_SH  = 8;
   localparam int SHIFT_W   = PROD_W - SCALE_SH;
   localparam int VSUM_W    = SHIFT_W + 1;
   localparam int VAL_W     = 24;
   localparam int SQ_W      = 2 * VAL_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 40;
   localparam int REQ_DAT_W = 3 * ACCEL_W + TIME_W;
   localparam int RSP_FLD_W = MODE_W + 3 + MAG_W;
   localparam int RSP_DAT_W = ((RSP_FLD_W + 7) / 8) * 8;

   localparam logic [TIME_W-1:0] FALL_WAIT_SECONDS   = TIME_W'(0);
   localparam logic [TIME_W-1:0] LYING_LIMIT_SECONDS = TIME_W'(10);

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_X   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_Y   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_Z   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_X = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Y = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Z = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_IMPACT   = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_RISE     = CSR_IDX_W'(7);

   localparam logic [GAIN_W-1:0]          GAIN_X_RST   = 16'd3098;
   localparam logic [GAIN_W-1:0]          GAIN_Y_RST   = 16'd3078;
   localparam logic [GAIN_W-1:0]          GAIN_Z_RST   = 16'd3039;
   localparam logic signed [OFFSET_W-1:0] OFFSET_X_RST = -17'sd2163;
   localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RST = -17'sd655;
   localparam logic signed [OFFSET_W-1:0] OFFSET_Z_RST = 17'sd852;
   localparam logic [LEVEL_W-1:0]         IMPACT_RST   = 40'd79413945303;
   localparam logic [LEVEL_W-1:0]         RISE_RST     = 40'd9663676416;

   typedef struct packed {
      logic [MAG_W-1:0]  magnitude_sq;
      logic              lying_alarm;
      logic              stood_up;
      logic              impact_alert;
      logic [MODE_W-1:0] mode_now;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/afd_lane.sv
// One axis lane: scale, offset, magnitude and square of a raw sample.
`default_nettype none
module afd_lane (
   input  logic                                  clock,
   input  logic                                  load,
   input  logic signed [afd_pkg::ACCEL_W-1:0]    raw,
   input  logic        [afd_pkg::GAIN_W-1:0]     gain,
   input  logic signed [afd_pkg::OFFSET_W-1:0]   offset,
   output logic        [afd_pkg::SQ_W-1:0]       square
);

   logic signed [afd_pkg::ACCEL_W-1:0] raw_ff, raw_in;
   logic signed [afd_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [afd_pkg::SHIFT_W-1:0] shifted;
   logic signed [afd_pkg::VSUM_W-1:0]  value;
   logic        [afd_pkg::VSUM_W-1:0]  value_abs;
   logic        [afd_pkg::VAL_W-1:0]   abs_ff, abs_in;
   logic        [afd_pkg::SQ_W-1:0]    sq_ff, sq_in;

   assign raw_in    = load ? raw : raw_ff;
   assign prod_in   = raw_ff * $signed({1'b0, gain});
   assign shifted   = prod_ff[afd_pkg::PROD_W-1:afd_pkg::SCALE_SH];
   assign value     = $signed({shifted[afd_pkg::SHIFT_W-1], shifted})
                    + $signed({{(afd_pkg::VSUM_W-afd_pkg::OFFSET_W){offset[afd_pkg::OFFSET_W-1]}},
                               offset});
   assign value_abs = value[afd_pkg::VSUM_W-1] ? (~value + afd_pkg::VSUM_W'(1)) : value;
   assign abs_in    = value_abs[afd_pkg::VAL_W-1:0];
   assign sq_in     = afd_pkg::SQ_W'(abs_ff) * afd_pkg::SQ_W'(abs_ff);
   assign square    = sq_ff;

   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      prod_ff <= prod_in;
      abs_ff  <= abs_in;
      sq_ff   <= sq_in;
   end

endmodule
`default_nettype wire

FILE: rtl/afd_merge.sv
// Lane merge: sum of squares, level compares and the fall state machine.
`default_nettype none
module afd_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [afd_pkg::SQ_W-1:0]           sq_x,
   input  logic [afd_pkg::SQ_W-1:0]           sq_y,
   input  logic [afd_pkg::SQ_W-1:0]           sq_z,
   input  logic [afd_pkg::TIME_W-1:0]         now_time,
   input  logic [afd_pkg::LEVEL_W-1:0]        impact_level,
   input  logic [afd_pkg::LEVEL_W-1:0]        rise_level,
   output afd_pkg::result_type                result
);

   typedef enum logic [afd_pkg::MODE_W-1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_WAITING = 2'd1,
      MODE_FALLEN  = 2'd2,
      MODE_LYING   = 2'd3
   } mode_type;

   mode_type                         mode_ff, mode_in;
   logic [afd_pkg::TIME_W-1:0]       impact_time_ff, impact_time_in;
   logic [afd_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [afd_pkg::TIME_W-1:0]       elapsed;
   logic                             over_impact, over_rise;
   logic                             impact, stood, alarm;

   assign sum_in      = afd_pkg::SUM_W'(sq_x) + afd_pkg::SUM_W'(sq_y) + afd_pkg::SUM_W'(sq_z);
   assign elapsed     = now_time - impact_time_ff;
   assign over_impact = sum_ff > afd_pkg::SUM_W'(impact_level);
   assign over_rise   = sum_ff > afd_pkg::SUM_W'(rise_level);

   always_comb begin
      mode_in        = mode_ff;
      impact_time_in = impact_time_ff;
      impact         = 1'b0;
      stood          = 1'b0;
      alarm          = 1'b0;
      case (mode_ff)
         MODE_NORMAL: begin
            if (over_impact) begin
               impact         = 1'b1;
               impact_time_in = now_time;
               mode_in        = MODE_WAITING;
            end
         end
         MODE_WAITING: begin
            if (elapsed > afd_pkg::FALL_WAIT_SECONDS) begin
               mode_in = MODE_FALLEN;
            end
         end
         MODE_FALLEN: begin
            if (over_rise) begin
               stood   = 1'b1;
               mode_in = MODE_NORMAL;
            end else if (elapsed > afd_pkg::LYING_LIMIT_SECONDS) begin
               alarm   = 1'b1;
               mode_in = MODE_LYING;
            end
         end
         default: begin
            mode_in = MODE_LYING;
         end
      endcase
   end

   always_comb begin
      result.mode_now     = mode_in;
      result.impact_alert = impact;
      result.stood_up     = stood;
      result.lying_alarm  = alarm;
      result.magnitude_sq = (sum_ff[afd_pkg::SUM_W-1:afd_pkg::MAG_W] != '0)
                          ? {afd_pkg::MAG_W{1'b1}} : sum_ff[afd_pkg::MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_NORMAL;
         impact_time_ff <= '0;
      end else if (step) begin
         mode_ff        <= mode_in;
         impact_time_ff <= impact_time_in;
      end
   end

`ifndef SYNTHESIS
   a_lying_holds : assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_LYING |=> mode_ff == MODE_LYING)
      else $error("still lying state left without reset");
   a_impact_waits : assert property (@(posedge clock) disable iff (reset)
      step && result.impact_alert |=> mode_ff == MODE_WAITING && impact_time_ff == $past(now_time))
      else $error("impact did not enter waiting with its timestamp");
   a_state_holds : assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(mode_ff) && $stable(impact_time_ff))
      else $error("state changed without a step");
`endif

endmodule
`default_nettype wire

FILE: rtl/accel_fall_detector.sv
// Top level of the accelerometer fall detector: ports, registers, sequencing.
//
//   channel  direction  handshake              payload
//   req_     in         req_tvalid/req_tready  req_tdata: x, y, z, now_seconds
//   rsp_     out        rsp_tvalid/rsp_tready  rsp_tdata: mode, flags, magnitude_sq
//   csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// Each request passes capture, three lane stages (product, offset and
// magnitude, square), the lane merge sum, then the state step into rsp_tdata.
// The step waits while the result register is full and not taken.
// A new request is taken once the previous one is stepped, while its result waits.
// Reset restores the configuration registers to defaults and the state to normal.
`default_nettype none
module accel_fall_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // accel_x[15:0], accel_y[31:16], accel_z[47:32], now_seconds[79:48]
   input  logic [afd_pkg::REQ_DAT_W-1:0]        req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // mode_now[1:0], impact_alert[2], stood_up[3], lying_alarm[4],
   // magnitude_sq[44:5], zero[47:45]
   output logic [afd_pkg::RSP_DAT_W-1:0]        rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [afd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [afd_pkg::CSR_DAT_W-1:0]        csr_data
);

   localparam logic [2:0] PHASE_LAST = 3'd4;

   logic [afd_pkg::GAIN_W-1:0]          gain_x_ff, gain_x_in;
   logic [afd_pkg::GAIN_W-1:0]          gain_y_ff, gain_y_in;
   logic [afd_pkg::GAIN_W-1:0]          gain_z_ff, gain_z_in;
   logic signed [afd_pkg::OFFSET_W-1:0] offset_x_ff, offset_x_in;
   logic signed [afd_pkg::OFFSET_W-1:0] offset_y_ff, offset_y_in;
   logic signed [afd_pkg::OFFSET_W-1:0] offset_z_ff, offset_z_in;
   logic [afd_pkg::LEVEL_W-1:0]         impact_ff, impact_in;
   logic [afd_pkg::LEVEL_W-1:0]         rise_ff, rise_in;

   logic                                busy_ff, busy_in;
   logic [2:0]                          phase_ff, phase_in;
   logic [afd_pkg::TIME_W-1:0]          now_ff, now_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   afd_pkg::result_type                 rsp_data_ff, rsp_data_in;

   logic                                accept, step;
   logic [afd_pkg::SQ_W-1:0]            sq_x, sq_y, sq_z;
   afd_pkg::result_type                 result;

   assign accept     = req_tvalid && req_tready;
   assign step       = busy_ff && (phase_ff == PHASE_LAST) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(afd_pkg::RSP_DAT_W-afd_pkg::RSP_FLD_W)'(0),
                        rsp_data_ff.magnitude_sq, rsp_data_ff.lying_alarm,
                        rsp_data_ff.stood_up, rsp_data_ff.impact_alert,
                        rsp_data_ff.mode_now};

   afd_lane u_lane_x (
      .clock  (clock),
      .load   (accept),
      .raw    ($signed(req_tdata[afd_pkg::ACCEL_W-1:0])),
      .gain   (gain_x_ff),
      .offset (offset_x_ff),
      .square (sq_x)
   );

   afd_lane u_lane_y (
      .clock  (clock),
      .load   (accept),
      .raw    ($signed(req_tdata[2*afd_pkg::ACCEL_W-1:afd_pkg::ACCEL_W])),
      .gain   (gain_y_ff),
      .offset (offset_y_ff),
      .square (sq_y)
   );

   afd_lane u_lane_z (
      .clock  (clock),
      .load   (accept),
      .raw    ($signed(req_tdata[3*afd_pkg::ACCEL_W-1:2*afd_pkg::ACCEL_W])),
      .gain   (gain_z_ff),
      .offset (offset_z_ff),
      .square (sq_z)
   );

   afd_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .sq_x         (sq_x),
      .sq_y         (sq_y),
      .sq_z         (sq_z),
      .now_time     (now_ff),
      .impact_level (impact_ff),
      .rise_level   (rise_ff),
      .result       (result)
   );

   always_comb begin
      gain_x_in   = gain_x_ff;
      gain_y_in   = gain_y_ff;
      gain_z_in   = gain_z_ff;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      offset_z_in = offset_z_ff;
      impact_in   = impact_ff;
      rise_in     = rise_ff;
      if (csr_valid) begin
         case (csr_index)
            afd_pkg::REG_GAIN_X:   gain_x_in   = csr_data[afd_pkg::GAIN_W-1:0];
            afd_pkg::REG_GAIN_Y:   gain_y_in   = csr_data[afd_pkg::GAIN_W-1:0];
            afd_pkg::REG_GAIN_Z:   gain_z_in   = csr_data[afd_pkg::GAIN_W-1:0];
            afd_pkg::REG_OFFSET_X: offset_x_in = $signed(csr_data[afd_pkg::OFFSET_W-1:0]);
            afd_pkg::REG_OFFSET_Y: offset_y_in = $signed(csr_data[afd_pkg::OFFSET_W-1:0]);
            afd_pkg::REG_OFFSET_Z: offset_z_in = $signed(csr_data[afd_pkg::OFFSET_W-1:0]);
            afd_pkg::REG_IMPACT:   impact_in   = csr_data[afd_pkg::LEVEL_W-1:0];
            afd_pkg::REG_RISE:     rise_in     = csr_data[afd_pkg::LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      phase_in     = phase_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in  = 1'b1;
         phase_in = '0;
         now_in   = req_tdata[afd_pkg::REQ_DAT_W-1:3*afd_pkg::ACCEL_W];
      end else if (busy_ff && phase_ff != PHASE_LAST) begin
         phase_in = phase_ff + 3'd1;
      end
      if (step) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_x_ff    <= afd_pkg::GAIN_X_RST;
         gain_y_ff    <= afd_pkg::GAIN_Y_RST;
         gain_z_ff    <= afd_pkg::GAIN_Z_RST;
         offset_x_ff  <= afd_pkg::OFFSET_X_RST;
         offset_y_ff  <= afd_pkg::OFFSET_Y_RST;
         offset_z_ff  <= afd_pkg::OFFSET_Z_RST;
         impact_ff    <= afd_pkg::IMPACT_RST;
         rise_ff      <= afd_pkg::RISE_RST;
         busy_ff      <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_x_ff    <= gain_x_in;
         gain_y_ff    <= gain_y_in;
         gain_z_ff    <= gain_z_in;
         offset_x_ff  <= offset_x_in;
         offset_y_ff  <= offset_y_in;
         offset_z_ff  <= offset_z_in;
         impact_ff    <= impact_in;
         rise_ff      <= rise_in;
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_step_loads : assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_tvalid && !busy_ff)
      else $error("step did not load the result register");
   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && phase_ff == 3'd0)
      else $error("accepted request did not start the lanes");
   a_no_early_release : assert property (@(posedge clock) disable iff (reset)
      busy_ff && phase_ff != PHASE_LAST |=> busy_ff && phase_ff == $past(phase_ff) + 3'd1)
      else $error("request released before the merge");
`endif

endmodule
`default_nettype wire
